FILE: hdl/slac_pkg.sv
package slac_pkg;

  // Fixed field widths
  localparam int ADDR_W       = 64;
  localparam int TAG_W        = 64;
  localparam int AGE_W        = 32;
  localparam int CNT_W        = 32;
  localparam int FUNC_W       = 2;
  localparam int SET_BITS_W   = 4;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  // set_bits is at most 15, so the masked index fits in 15 bits
  localparam int IDX_W        = 15;

  // Access kinds
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  // One cache line as stored in a set row
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } slac_line_t;

  localparam int LINE_W = $bits(slac_line_t);

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_UPDATE
  } slac_state_t;

endpackage

FILE: hdl/slac_ram.sv
module slac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/slac_queue.sv
module slac_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = slot[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hdl/slac_front.sv
module slac_front
  import slac_pkg::*;
#(
  parameter int MAX_SETS = 256
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       hold,
  input  logic [SET_BITS_W-1:0]                      set_bits,
  input  logic [BLOCK_BITS_W-1:0]                    block_bits,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [FUNC_W-1:0]                          func,
  input  logic [ADDR_W-1:0]                          address,
  input  logic                                       queue_full,
  output logic                                       push,
  output logic [TAG_W-1:0]                           push_tag,
  output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] push_set,
  output logic [AGE_W-1:0]                           push_stamp,
  output logic                                       push_modify
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int MW    = $clog2(MAX_SETS + 1);
  // ceil(2^32 / MAX_SETS): exact quotient for any 15-bit index
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << 32) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS);
  localparam logic [32:0] RECIP = RECIP_FULL[32:0];

  logic [AGE_W-1:0] stamp;

  logic             s1_v;
  logic [TAG_W-1:0] s1_tag;
  logic [IDX_W-1:0] s1_idx;
  logic [AGE_W-1:0] s1_stamp;
  logic             s1_mod;

  logic             s2_v;
  logic [TAG_W-1:0] s2_tag;
  logic [IDX_W-1:0] s2_idx;
  logic [IDX_W-1:0] s2_q;
  logic [AGE_W-1:0] s2_stamp;
  logic             s2_mod;

  logic                    known_func;
  logic                    accept;
  logic                    load1;
  logic                    s1_adv;
  logic [6:0]              tag_shift;
  logic [ADDR_W-1:0]       idx_shifted;
  logic [IDX_W:0]          idx_mask;
  logic [TAG_W-1:0]        tag_calc;
  logic [IDX_W-1:0]        idx_calc;
  logic [IDX_W+32:0]       recip_prod;
  logic [IDX_W+MW-1:0]     q_times_m;
  logic [IDX_W-1:0]        set_rem;

  // Stage handshake
  assign push       = s2_v && !queue_full;
  assign s1_adv     = s1_v && (!s2_v || push);
  assign in_ready   = !hold && (!s1_v || s1_adv);
  assign accept     = in_valid && in_ready;
  assign known_func = (func == FUNC_LOAD) || (func == FUNC_STORE) || (func == FUNC_MODIFY);
  assign load1      = accept && known_func;

  // Tag and raw set index from the address
  assign tag_shift   = {3'b000, set_bits} + {1'b0, block_bits};
  assign tag_calc    = tag_shift[6] ? '0 : (address >> tag_shift[5:0]);
  assign idx_shifted = address >> block_bits;
  assign idx_mask    = ({{IDX_W{1'b0}}, 1'b1} << set_bits) - {{IDX_W{1'b0}}, 1'b1};
  assign idx_calc    = idx_shifted[IDX_W-1:0] & idx_mask[IDX_W-1:0];

  // Index modulo MAX_SETS: reciprocal quotient, then remainder
  assign recip_prod = s1_idx * RECIP;
  assign q_times_m  = s2_q * MW'(MAX_SETS);
  assign set_rem    = s2_idx - q_times_m[IDX_W-1:0];

  assign push_tag    = s2_tag;
  assign push_set    = set_rem[SET_W-1:0];
  assign push_stamp  = s2_stamp;
  assign push_modify = s2_mod;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp <= '0;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
    end else begin
      if (load1) stamp <= stamp + 32'd1;
      if (load1) s1_v <= 1'b1;
      else if (s1_adv) s1_v <= 1'b0;
      if (s1_adv) s2_v <= 1'b1;
      else if (push) s2_v <= 1'b0;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (load1) begin
      s1_tag   <= tag_calc;
      s1_idx   <= idx_calc;
      s1_stamp <= stamp + 32'd1;
      s1_mod   <= (func == FUNC_MODIFY);
    end
    if (s1_adv) begin
      s2_tag   <= s1_tag;
      s2_idx   <= s1_idx;
      s2_q     <= recip_prod[IDX_W+31:32];
      s2_stamp <= s1_stamp;
      s2_mod   <= s1_mod;
    end
  end

endmodule

FILE: hdl/slac_back.sv
module slac_back
  import slac_pkg::*;
#(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [WAYS_W-1:0]                          ways_used,
  output logic                                       clearing,
  input  logic                                       q_valid,
  input  logic [TAG_W-1:0]                           q_tag,
  input  logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] q_set,
  input  logic [AGE_W-1:0]                           q_stamp,
  input  logic                                       q_modify,
  output logic                                       q_pop,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic                                       out_hit,
  output logic                                       out_evicted,
  output logic [CNT_W-1:0]                           out_hit_total,
  output logic [CNT_W-1:0]                           out_miss_total,
  output logic [CNT_W-1:0]                           out_evict_total,
  output logic                                       out_last
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WI_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WC_W  = $clog2(MAX_WAYS + 1);
  localparam int ROW_W = MAX_WAYS * LINE_W;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  slac_state_t state, state_next;

  logic [SET_W-1:0]  clr_addr;
  logic              second;
  logic [CNT_W-1:0]  hits;
  logic [CNT_W-1:0]  misses;
  logic [CNT_W-1:0]  evicts;

  slac_line_t [MAX_WAYS-1:0] row;
  slac_line_t [MAX_WAYS-1:0] row_new;
  logic [WI_W-1:0]   way;
  logic              hit;
  logic [WI_W-1:0]   hit_way;
  logic              have_empty;
  logic [WI_W-1:0]   empty_way;
  logic              have_victim;
  logic [WI_W-1:0]   victim_way;
  logic [AGE_W-1:0]  victim_age;

  logic [WC_W-1:0]   ways_eff;
  logic              last_way;
  slac_line_t        cur;
  logic              hit_now;
  logic              victim_now;
  logic              empty_now;
  logic              fire;
  logic              item_done;
  logic [WI_W-1:0]   fill_way;

  logic              ram_we;
  logic [SET_W-1:0]  ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ROW_W-1:0]  ram_rdata;

  slac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_set),
    .rdata (ram_rdata)
  );

  // Ways in use: zero acts as one, large values clamp
  always_comb begin
    if (ways_used == '0) ways_eff = WC_W'(1);
    else if ({2'b00, ways_used} > 6'(MAX_WAYS)) ways_eff = WC_W'(MAX_WAYS);
    else ways_eff = WC_W'(ways_used);
  end

  // One way of the scan
  assign cur        = row[way];
  assign last_way   = (WC_W'(way) + WC_W'(1)) == ways_eff;
  assign hit_now    = cur.valid && !hit && (cur.tag == q_tag);
  assign victim_now = cur.valid && !hit_now && (!have_victim || (cur.age < victim_age));
  assign empty_now  = !cur.valid && !have_empty;
  assign fill_way   = have_empty ? empty_way : victim_way;

  // Updated set row
  always_comb begin
    row_new = row;
    if (hit) begin
      row_new[hit_way].age = q_stamp;
    end else begin
      row_new[fill_way].valid = 1'b1;
      row_new[fill_way].tag   = q_tag;
      row_new[fill_way].age   = q_stamp;
    end
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    fire       = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = q_set;
    ram_wdata  = row_new;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == SET_W'(MAX_SETS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          ram_re     = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_way) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!out_valid || out_ready) begin
          fire       = 1'b1;
          ram_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign item_done = fire && !(q_modify && !second);
  assign q_pop     = item_done;
  assign clearing  = (state == ST_CLEAR);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      second    <= 1'b0;
      hits      <= '0;
      misses    <= '0;
      evicts    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + SET_W'(1);
      if (fire) begin
        second <= !item_done;
        if (hit) begin
          hits <= sat_inc(hits);
        end else begin
          misses <= sat_inc(misses);
          if (!have_empty) evicts <= sat_inc(evicts);
        end
      end
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Scan and result datapath
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      row         <= ram_rdata;
      way         <= '0;
      hit         <= 1'b0;
      have_empty  <= 1'b0;
      have_victim <= 1'b0;
    end
    if (state == ST_SCAN) begin
      way <= way + WI_W'(1);
      if (hit_now) begin
        hit     <= 1'b1;
        hit_way <= way;
      end
      if (victim_now) begin
        have_victim <= 1'b1;
        victim_way  <= way;
        victim_age  <= cur.age;
      end
      if (empty_now) begin
        have_empty <= 1'b1;
        empty_way  <= way;
      end
    end
    if (fire) begin
      out_hit         <= hit;
      out_evicted     <= !hit && !have_empty;
      out_hit_total   <= hit ? sat_inc(hits) : hits;
      out_miss_total  <= hit ? misses : sat_inc(misses);
      out_evict_total <= (!hit && !have_empty) ? sat_inc(evicts) : evicts;
      out_last        <= item_done;
    end
  end

  // The entry under work stays at the queue head
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_SCAN || state == ST_UPDATE) |-> q_valid)
    else $error("queue head lost during an access");

  // Scan never runs past the ways in use
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (WC_W'(way) < ways_eff))
    else $error("way scan out of range");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit and eviction on one result");

  // Running counts never decrease
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (hits >= $past(hits) && misses >= $past(misses)
                     && evicts >= $past(evicts)))
    else $error("running count went down");

endmodule

FILE: hdl/set_assoc_lru_cache_sim.sv
// Channel | Direction | Handshake           | Payload
// cfg     | in        | cfg_we              | cfg_index, cfg_data
// in      | in        | in_valid / in_ready | func, address
// out     | out       | out_valid/out_ready | hit, evicted, hit_total, miss_total,
//         |           |                     | evict_total, last
//
// Each access runs through the back end in steps: set row read, capture,
// one way examined per cycle, then the row write; a modify costs two accesses.
// The front end registers items in stages s1 and s2, buffering up to two ahead.
// After reset a clearing pass writes all MAX_SETS set rows, one per cycle;
// in_ready stays low until it ends. Configuration writes are taken at once.
// A stalled result holds the back end in its write step; the front keeps going.
module set_assoc_lru_cache_sim
  import slac_pkg::*;
#(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     func,
  input  logic [ADDR_W-1:0]     address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic                  evicted,
  output logic [CNT_W-1:0]      hit_total,
  output logic [CNT_W-1:0]      miss_total,
  output logic [CNT_W-1:0]      evict_total,
  output logic                  last
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int Q_W   = TAG_W + SET_W + AGE_W + 1;

  logic [SET_BITS_W-1:0]   set_bits;
  logic [WAYS_W-1:0]       ways_used;
  logic [BLOCK_BITS_W-1:0] block_bits;

  logic             clearing;
  logic             queue_full;
  logic             push;
  logic [TAG_W-1:0] push_tag;
  logic [SET_W-1:0] push_set;
  logic [AGE_W-1:0] push_stamp;
  logic             push_modify;
  logic             q_valid;
  logic             q_pop;
  logic [Q_W-1:0]   q_data;
  logic [TAG_W-1:0] q_tag;
  logic [SET_W-1:0] q_set;
  logic [AGE_W-1:0] q_stamp;
  logic             q_modify;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 4'd4;
      ways_used  <= 4'd1;
      block_bits <= 6'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS:   set_bits   <= cfg_data[SET_BITS_W-1:0];
        CFG_WAYS_USED:  ways_used  <= cfg_data[WAYS_W-1:0];
        CFG_BLOCK_BITS: block_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  slac_front #(
    .MAX_SETS (MAX_SETS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .hold        (clearing),
    .set_bits    (set_bits),
    .block_bits  (block_bits),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .address     (address),
    .queue_full  (queue_full),
    .push        (push),
    .push_tag    (push_tag),
    .push_set    (push_set),
    .push_stamp  (push_stamp),
    .push_modify (push_modify)
  );

  slac_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_tag, push_set, push_stamp, push_modify}),
    .full      (queue_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  assign {q_tag, q_set, q_stamp, q_modify} = q_data;

  slac_back #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .ways_used       (ways_used),
    .clearing        (clearing),
    .q_valid         (q_valid),
    .q_tag           (q_tag),
    .q_set           (q_set),
    .q_stamp         (q_stamp),
    .q_modify        (q_modify),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (hit),
    .out_evicted     (evicted),
    .out_hit_total   (hit_total),
    .out_miss_total  (miss_total),
    .out_evict_total (evict_total),
    .out_last        (last)
  );

endmodule
